// ===== rtl/core/tpfs_pkg.sv =====
// ----------------------------------------------------------------------------
// tpfs_pkg
// Shared types and constants of the thermal packet frame synchronizer.
// ----------------------------------------------------------------------------
package tpfs_pkg;

    // Stream geometry.
    localparam int PACKET_BYTES        = 164;
    localparam int PACKETS_PER_SEGMENT = 60;
    localparam int SEGMENTS            = 4;
    localparam int SEGMENT_ID_PACKET   = 20;
    localparam int FRAME_PACKETS       = PACKETS_PER_SEGMENT * SEGMENTS;

    localparam int OFF_W = $clog2(PACKET_BYTES);
    localparam int IDX_W = $clog2(FRAME_PACKETS);
    localparam int SEG_W = $clog2(PACKETS_PER_SEGMENT);

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 16;
    localparam int TALLY_W = 16;
    localparam int DLIM_W  = 10;
    localparam int RLIM_W  = 8;
    localparam int MLIM_W  = 8;
    localparam int SRCH_W  = 11;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_DISCARD_LIMIT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESYNC_LIMIT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MISMATCH_LIMIT = 2'd2;

    localparam logic [DLIM_W-1:0] DISCARD_LIMIT_RESET  = 10'd120;
    localparam logic [RLIM_W-1:0] RESYNC_LIMIT_RESET   = 8'd50;
    localparam logic [MLIM_W-1:0] MISMATCH_LIMIT_RESET = 8'd10;

    // Header codes.
    localparam logic [3:0]        DISCARD_NIBBLE = 4'hF;
    localparam logic [BYTE_W-1:0] SEG_ID_MASK    = 8'h70;
    localparam logic [BYTE_W-1:0] SEG_ID_ONE     = 8'h10;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified byte as handed from front to back.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [OFF_W-1:0]  offset;
        logic              first;
        logic              second;
        logic              last;
    } item_t;

    // One result of the back part.
    typedef struct packed {
        logic               store_enable;
        logic [ADDR_W-1:0]  store_address;
        logic [BYTE_W-1:0]  store_byte;
        logic               frame_done;
        logic               frame_discard;
        logic               camera_reset;
        logic [TALLY_W-1:0] read_error_count;
        logic [TALLY_W-1:0] check_error_count;
    } result_t;

endpackage

// ===== rtl/core/tpfs_ifs.sv =====
// ----------------------------------------------------------------------------
// tpfs channel interfaces
// Byte link, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface tpfs_byte_if;
    logic                       valid;
    logic                       ready;
    logic [tpfs_pkg::BYTE_W-1:0] spi_byte;

    modport source (output valid, output spi_byte, input ready);
    modport sink   (input valid, input spi_byte, output ready);
endinterface

interface tpfs_result_if;
    logic                         valid;
    logic                         ready;
    logic                         store_enable;
    logic [tpfs_pkg::ADDR_W-1:0]  store_address;
    logic [tpfs_pkg::BYTE_W-1:0]  store_byte;
    logic                         frame_done;
    logic                         frame_discard;
    logic                         camera_reset;
    logic [tpfs_pkg::TALLY_W-1:0] read_error_count;
    logic [tpfs_pkg::TALLY_W-1:0] check_error_count;

    modport source (output valid, output store_enable, output store_address,
                    output store_byte, output frame_done, output frame_discard,
                    output camera_reset, output read_error_count,
                    output check_error_count, input ready);
    modport sink   (input valid, input store_enable, input store_address,
                    input store_byte, input frame_done, input frame_discard,
                    input camera_reset, input read_error_count,
                    input check_error_count, output ready);
endinterface

interface tpfs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [tpfs_pkg::CFG_INDEX_W-1:0] index;
    logic [tpfs_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/tpfs_front.sv =====
// ----------------------------------------------------------------------------
// tpfs_front
// Accepts link bytes, tracks the byte offset within a packet and tags each
// byte with its position flags before pushing it into the queue.
// ----------------------------------------------------------------------------
module tpfs_front (
    input  logic                clk,
    input  logic                rst_n,
    tpfs_byte_if.sink           link,
    input  logic                full,
    output logic                push,
    output tpfs_pkg::item_t     push_item
);

    logic [tpfs_pkg::OFF_W-1:0] offset_reg;
    logic [tpfs_pkg::OFF_W-1:0] offset_next;

    // A request is taken whenever the queue has room.
    assign link.ready = !full;
    assign push       = link.valid && !full;

    // Classify the byte by its place in the packet.
    always_comb
    begin
        push_item.data   = link.spi_byte;
        push_item.offset = offset_reg;
        push_item.first  = (offset_reg == '0);
        push_item.second = (offset_reg == tpfs_pkg::OFF_W'(1));
        push_item.last   = (offset_reg == tpfs_pkg::OFF_W'(tpfs_pkg::PACKET_BYTES - 1));
    end

    // The offset advances on every accepted byte and wraps at the packet end.
    always_comb
    begin
        offset_next = offset_reg;
        if (push)
        begin
            if (push_item.last)
            begin
                offset_next = '0;
            end
            else
            begin
                offset_next = offset_reg + tpfs_pkg::OFF_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else
        begin
            offset_reg <= offset_next;
        end
    end

endmodule

// ===== rtl/core/tpfs_queue.sv =====
// ----------------------------------------------------------------------------
// tpfs_queue
// Short first-in first-out buffer that decouples the front from the back.
// ----------------------------------------------------------------------------
module tpfs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tpfs_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output tpfs_pkg::item_t q_item
);

    tpfs_pkg::item_t               slot_reg [tpfs_pkg::QUEUE_DEPTH];
    logic [tpfs_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [tpfs_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [tpfs_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [tpfs_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [tpfs_pkg::QCNT_W-1:0]   count_reg;
    logic [tpfs_pkg::QCNT_W-1:0]   count_next;

    assign full    = (count_reg == tpfs_pkg::QCNT_W'(tpfs_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + tpfs_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + tpfs_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + tpfs_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - tpfs_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/tpfs_back.sv =====
// ----------------------------------------------------------------------------
// tpfs_back
// Frame synchronization state machine: search, segment-one check, blind
// store of the remaining segments, packet number check, retry counters and
// error tallies. Holds the configuration registers and the result register.
// ----------------------------------------------------------------------------
module tpfs_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  tpfs_pkg::item_t q_item,
    output logic            pop,
    tpfs_cfg_if.sink        cfg,
    tpfs_result_if.source   frame
);

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_FIRST  = 2'd1,
        PH_BLIND  = 2'd2
    } phase_t;

    function automatic logic [tpfs_pkg::TALLY_W-1:0] sat_inc(
        input logic [tpfs_pkg::TALLY_W-1:0] v
    );
        return (&v) ? v : v + tpfs_pkg::TALLY_W'(1);
    endfunction

    // Configuration registers.
    logic [tpfs_pkg::DLIM_W-1:0]  discard_limit_reg;
    logic [tpfs_pkg::RLIM_W-1:0]  resync_limit_reg;
    logic [tpfs_pkg::MLIM_W-1:0]  mismatch_limit_reg;

    // Frame state.
    phase_t                       phase_reg,      phase_next;
    logic [tpfs_pkg::IDX_W-1:0]   index_reg,      index_next;
    logic [tpfs_pkg::SEG_W-1:0]   seg_pkt_reg,    seg_pkt_next;
    logic [tpfs_pkg::ADDR_W-1:0]  base_reg,       base_next;
    logic [tpfs_pkg::SRCH_W-1:0]  search_reg,     search_next;
    logic [tpfs_pkg::RLIM_W-1:0]  retries_reg,    retries_next;
    logic [tpfs_pkg::MLIM_W-1:0]  bad_reg,        bad_next;
    logic                         seg_one_reg,    seg_one_next;
    logic                         mismatch_reg,   mismatch_next;
    logic [tpfs_pkg::TALLY_W-1:0] read_tally_reg, read_tally_next;
    logic [tpfs_pkg::TALLY_W-1:0] check_tally_reg, check_tally_next;

    // Result register.
    logic                         out_valid_reg,  out_valid_next;
    tpfs_pkg::result_t            result_reg,     result_next;

    logic                         seg_end;

    // An item is processed when the result register is free or being emptied.
    assign pop       = q_valid && (!out_valid_reg || frame.ready);
    assign cfg.ready = 1'b1;

    assign frame.valid             = out_valid_reg;
    assign frame.store_enable      = result_reg.store_enable;
    assign frame.store_address     = result_reg.store_address;
    assign frame.store_byte        = result_reg.store_byte;
    assign frame.frame_done        = result_reg.frame_done;
    assign frame.frame_discard     = result_reg.frame_discard;
    assign frame.camera_reset      = result_reg.camera_reset;
    assign frame.read_error_count  = result_reg.read_error_count;
    assign frame.check_error_count = result_reg.check_error_count;

    // Per-byte state update and result.
    always_comb
    begin
        phase_next       = phase_reg;
        index_next       = index_reg;
        seg_pkt_next     = seg_pkt_reg;
        base_next        = base_reg;
        search_next      = search_reg;
        retries_next     = retries_reg;
        bad_next         = bad_reg;
        seg_one_next     = seg_one_reg;
        mismatch_next    = mismatch_reg;
        read_tally_next  = read_tally_reg;
        check_tally_next = check_tally_reg;
        result_next      = '0;
        seg_end          = 1'b0;

        if (pop)
        begin
            unique case (phase_reg)
                PH_FIRST, PH_BLIND:
                begin
                    result_next.store_enable  = 1'b1;
                    result_next.store_byte    = q_item.data;
                    result_next.store_address = base_reg
                                              + tpfs_pkg::ADDR_W'(q_item.offset);

                    if (q_item.second
                        && (q_item.data != tpfs_pkg::BYTE_W'(seg_pkt_reg)))
                    begin
                        mismatch_next = 1'b1;
                    end
                    if ((phase_reg == PH_FIRST) && q_item.first
                        && (index_reg == tpfs_pkg::IDX_W'(tpfs_pkg::SEGMENT_ID_PACKET)))
                    begin
                        seg_one_next = ((q_item.data & tpfs_pkg::SEG_ID_MASK)
                                        == tpfs_pkg::SEG_ID_ONE);
                    end

                    if (q_item.last)
                    begin
                        seg_end = (phase_reg == PH_FIRST)
                               && (index_reg == tpfs_pkg::IDX_W'(
                                      tpfs_pkg::PACKETS_PER_SEGMENT - 1));
                        if (seg_end && !seg_one_next)
                        begin
                            // Segment one was not found: resume the search.
                            result_next.frame_discard = 1'b1;
                            phase_next   = PH_SEARCH;
                            index_next   = '0;
                            seg_pkt_next = '0;
                            base_next    = '0;
                        end
                        else if (index_reg >= tpfs_pkg::IDX_W'(
                                     tpfs_pkg::FRAME_PACKETS - 1))
                        begin
                            // End of frame: pass or count a bad frame.
                            if (!mismatch_next)
                            begin
                                result_next.frame_done = 1'b1;
                                bad_next = '0;
                            end
                            else
                            begin
                                result_next.frame_discard = 1'b1;
                                if (({1'b0, bad_reg} + 9'd1) > {1'b0, mismatch_limit_reg})
                                begin
                                    bad_next = '0;
                                    check_tally_next = sat_inc(check_tally_reg);
                                    result_next.camera_reset = 1'b1;
                                end
                                else
                                begin
                                    bad_next = bad_reg + tpfs_pkg::MLIM_W'(1);
                                end
                            end
                            retries_next = '0;
                            search_next  = '0;
                            phase_next   = PH_SEARCH;
                            index_next   = '0;
                            seg_pkt_next = '0;
                            base_next    = '0;
                        end
                        else
                        begin
                            // Next packet of the frame.
                            if (seg_end)
                            begin
                                phase_next = PH_BLIND;
                            end
                            index_next = index_reg + tpfs_pkg::IDX_W'(1);
                            base_next  = base_reg
                                       + tpfs_pkg::ADDR_W'(tpfs_pkg::PACKET_BYTES);
                            if (seg_pkt_reg == tpfs_pkg::SEG_W'(
                                    tpfs_pkg::PACKETS_PER_SEGMENT - 1))
                            begin
                                seg_pkt_next = '0;
                            end
                            else
                            begin
                                seg_pkt_next = seg_pkt_reg + tpfs_pkg::SEG_W'(1);
                            end
                        end
                    end
                end

                default:
                begin
                    // Searching: every decision is taken on a packet's first byte.
                    phase_next = PH_SEARCH;
                    if (q_item.first)
                    begin
                        if (search_reg > tpfs_pkg::SRCH_W'(discard_limit_reg))
                        begin
                            search_next = '0;
                            result_next.frame_discard = 1'b1;
                            if (({1'b0, retries_reg} + 9'd1) > {1'b0, resync_limit_reg})
                            begin
                                retries_next = '0;
                                read_tally_next = sat_inc(read_tally_reg);
                                result_next.camera_reset = 1'b1;
                            end
                            else
                            begin
                                retries_next = retries_reg + tpfs_pkg::RLIM_W'(1);
                            end
                        end
                        else
                        begin
                            search_next = search_reg + tpfs_pkg::SRCH_W'(1);
                            if (q_item.data[3:0] != tpfs_pkg::DISCARD_NIBBLE)
                            begin
                                phase_next    = PH_FIRST;
                                index_next    = '0;
                                seg_pkt_next  = '0;
                                base_next     = '0;
                                seg_one_next  = 1'b0;
                                mismatch_next = 1'b0;
                                result_next.store_enable = 1'b1;
                                result_next.store_byte   = q_item.data;
                            end
                        end
                    end
                end
            endcase
        end

        result_next.read_error_count  = read_tally_next;
        result_next.check_error_count = check_tally_next;
    end

    // Output register handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (frame.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state, configuration and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discard_limit_reg  <= tpfs_pkg::DISCARD_LIMIT_RESET;
            resync_limit_reg   <= tpfs_pkg::RESYNC_LIMIT_RESET;
            mismatch_limit_reg <= tpfs_pkg::MISMATCH_LIMIT_RESET;
            phase_reg          <= PH_SEARCH;
            index_reg          <= '0;
            seg_pkt_reg        <= '0;
            base_reg           <= '0;
            search_reg         <= '0;
            retries_reg        <= '0;
            bad_reg            <= '0;
            seg_one_reg        <= 1'b0;
            mismatch_reg       <= 1'b0;
            read_tally_reg     <= '0;
            check_tally_reg    <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    tpfs_pkg::CFG_DISCARD_LIMIT:
                        discard_limit_reg <= cfg.data;
                    tpfs_pkg::CFG_RESYNC_LIMIT:
                        resync_limit_reg <= cfg.data[tpfs_pkg::RLIM_W-1:0];
                    tpfs_pkg::CFG_MISMATCH_LIMIT:
                        mismatch_limit_reg <= cfg.data[tpfs_pkg::MLIM_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            phase_reg       <= phase_next;
            index_reg       <= index_next;
            seg_pkt_reg     <= seg_pkt_next;
            base_reg        <= base_next;
            search_reg      <= search_next;
            retries_reg     <= retries_next;
            bad_reg         <= bad_next;
            seg_one_reg     <= seg_one_next;
            mismatch_reg    <= mismatch_next;
            read_tally_reg  <= read_tally_next;
            check_tally_reg <= check_tally_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ===== rtl/core/thermal_packet_frame_sync_core.sv =====
// ----------------------------------------------------------------------------
// thermal_packet_frame_sync_core
// Frame synchronizer for a packetized thermal camera byte stream.
//
//   Channel  Role   Request carries
//   -------  -----  ----------------------------------------------------------
//   link     sink   spi_byte, one raw byte of the serial link
//   frame    source store_enable/address/byte, frame_done, frame_discard,
//                   camera_reset, read_error_count, check_error_count
//   cfg      sink   index (0 discard, 1 resync, 2 mismatch limit), data
//
// One byte per clock is sustained while frame.ready stays high; every byte
// gives exactly one result. The byte is written into the queue when it is
// accepted, and the back state machine registers its result when it pops the
// byte, which waits while the result register holds an untaken result.
// rst_n clears all counters and restores the limit registers to their
// defaults. A two-entry queue lets the link keep sending while a result
// waits on frame.ready; link.ready drops only when that queue is full.
// ----------------------------------------------------------------------------
module thermal_packet_frame_sync_core (
    input  logic          clk,
    input  logic          rst_n,
    tpfs_byte_if.sink     link,
    tpfs_result_if.source frame,
    tpfs_cfg_if.sink      cfg
);

    logic            push;
    tpfs_pkg::item_t push_item;
    logic            full;
    logic            pop;
    logic            q_valid;
    tpfs_pkg::item_t q_item;

    // Byte classification.
    tpfs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .link      (link),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    // Decoupling queue.
    tpfs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    // Synchronization state machine and result register.
    tpfs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .pop     (pop),
        .cfg     (cfg),
        .frame   (frame)
    );

endmodule
